// ----- src/cfre_pkg.sv -----
// Package for the compact format record encoder.
// Holds the action codes, the record header byte and the per-item byte list type.
// No dependencies.
`default_nettype none

package cfre_pkg;

  // Kinds of input transaction, carried on the slave tuser.
  localparam logic [1:0] ACT_FMT = 2'd0;
  localparam logic [1:0] ACT_STR = 2'd1;
  localparam logic [1:0] ACT_END = 2'd2;

  // Byte that stands for a percent sign in the record.
  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  // Top bit set on an integer conversion whose value fits in one byte.
  localparam logic [7:0] FLAG_BIT = 8'h80;

  // Most record bytes a single input transaction can cause.
  localparam int unsigned MAX_BYTES = 6;

  // Bytes produced by one input transaction, handed to the serialiser.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                n;
    logic                      done;
    logic                      clr;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/compact_format_record_encoder.sv -----
// Top level of the compact format record encoder.
// Registers each decoded transaction and serialises its bytes onto the output
// stream with a saturating byte count. Depends on cfre_pkg and cfre_encode.
//
//  channel | dir | tdata                              | tuser                        | tlast
//  s_axis  | in  | [7:0] char_in, [39:8] arg_value    | [1:0] action                 | -
//  m_axis  | out | [7:0] out_byte, [23:8] total_bytes | [0] byte_valid, [1] record_done | run_last
//
// An input transaction is decoded in the cycle it is accepted and its bytes
// (one to six, or one status result) go out one per cycle while the output is not
// stalled, from a byte list register through the output register; the next one is
// taken as the last result moves, so single-result transactions flow at one per cycle.
// Reset clears the mode, the character history, the byte count and both
// valid flags. A stall on the output holds the byte list and the input.
`default_nettype none

module compact_format_record_encoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [7:0] char_in, [39:8] arg_value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [7:0] out_byte, [23:8] total_bytes
  output logic [1:0]       m_axis_tuser,  // [0] byte_valid, [1] record_done
  output logic             m_axis_tlast
);

  cfre_pkg::entry_t entry_d, ent_q;
  logic             ent_v_q;
  logic [2:0]       idx_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, base;
  logic             accept, out_free, move, is_byte, is_last, last_move;
  logic [7:0]       byte_sel;
  logic [15:0]      total_w;
  logic             m_valid_q;
  logic [23:0]      m_data_q;
  logic [1:0]       m_user_q;
  logic             m_last_q;

  cfre_encode u_encode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (s_axis_tuser),
    .char_i   (s_axis_tdata[7:0]),
    .arg_i    (s_axis_tdata[39:8]),
    .entry_o  (entry_d)
  );

  // Handshake between the byte list register and the output register.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign move          = ent_v_q && out_free;
  assign is_byte       = ent_q.n != 3'd0;
  assign is_last       = !is_byte || (idx_q == ent_q.n - 3'd1);
  assign last_move     = move && is_last;
  assign s_axis_tready = !ent_v_q || last_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Current result and the saturating byte count it reports.
  always_comb begin
    base     = (idx_q == 3'd0 && ent_q.clr) ? '0 : cnt_q;
    cnt_d    = (is_byte && base != '1) ? base + 1'b1 : base;
    byte_sel = is_byte ? ent_q.bytes[idx_q] : 8'h00;
  end

  generate
    if (COUNT_WIDTH > 16) begin : g_sat_view
      assign total_w = (|cnt_d[COUNT_WIDTH-1:16]) ? 16'hFFFF : cnt_d[15:0];
    end else begin : g_full_view
      assign total_w = 16'(cnt_d);
    end
  endgenerate

  // Byte list register and serialiser index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      idx_q   <= 3'd0;
      cnt_q   <= '0;
    end else begin
      if (move) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        ent_v_q <= 1'b1;
        idx_q   <= 3'd0;
      end else if (last_move) begin
        ent_v_q <= 1'b0;
      end else if (move) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= entry_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      m_data_q <= {total_w, byte_sel};
      m_user_q <= {ent_q.done, is_byte};
      m_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // A status result carries a zero byte and closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h00 && m_axis_tlast))
    else $error("status result malformed");

  // The serialiser index stays inside the byte list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_v_q |-> (idx_q < ent_q.n || (ent_q.n == 3'd0 && idx_q == 3'd0)))
    else $error("serialiser index out of range");

  // The byte count only falls when a new record begins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |-> (cnt_d >= cnt_q || (idx_q == 3'd0 && ent_q.clr)))
    else $error("byte count went backwards");

  // After the last byte leaves with nothing new taken, the list is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_move && !accept) |=> !ent_v_q)
    else $error("byte list not released");

endmodule

`default_nettype wire

// ----- src/cfre_encode.sv -----
// Format string decoder of the compact format record encoder.
// Keeps the encoder mode and the last two format characters, and turns one
// input transaction into its list of record bytes. Depends on cfre_pkg.
`default_nettype none

module cfre_encode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [1:0]      action_i,
  input  wire logic [7:0]      char_i,
  input  wire logic [31:0]     arg_i,
  output cfre_pkg::entry_t     entry_o
);

  localparam logic [2:0] MODE_PLAIN      = 3'd0;
  localparam logic [2:0] MODE_SPEC_FIRST = 3'd1;
  localparam logic [2:0] MODE_SPEC       = 3'd2;
  localparam logic [2:0] MODE_STR_BARE   = 3'd3;
  localparam logic [2:0] MODE_STR_INCL   = 3'd4;
  localparam logic [2:0] MODE_DONE       = 3'd5;

  logic [2:0] mode_q, mode_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] prev2_q, prev2_d;

  logic [cfre_pkg::MAX_BYTES-1:0][7:0] b;
  logic [2:0] n;
  logic [2:0] m;
  logic [7:0] p1, p2;
  logic [7:0] fc;
  logic       clr;
  logic       do_fmt;
  logic       conv;
  logic [2:0] len;

  // Decode one transaction into its record bytes and the next mode.
  always_comb begin
    b      = '0;
    n      = 3'd0;
    m      = mode_q;
    p1     = prev_q;
    p2     = prev2_q;
    clr    = 1'b0;
    conv   = 1'b0;
    len    = 3'd4;
    fc     = (action_i == cfre_pkg::ACT_FMT) ? char_i : 8'h00;

    // A nonzero format character after the end opens a new record.
    if (action_i == cfre_pkg::ACT_FMT && m == MODE_DONE && char_i != 8'h00) begin
      clr = 1'b1;
      m   = MODE_PLAIN;
      p1  = 8'h00;
      p2  = 8'h00;
    end

    do_fmt = (action_i == cfre_pkg::ACT_FMT || action_i == cfre_pkg::ACT_END) &&
             m != MODE_DONE;
    prev_d  = prev_q;
    prev2_d = prev2_q;
    if (action_i == cfre_pkg::ACT_FMT && m != MODE_DONE) begin
      prev_d  = char_i;
      prev2_d = p1;
    end else if (clr) begin
      prev_d  = p1;
      prev2_d = p2;
    end

    // String argument bytes.
    if (action_i == cfre_pkg::ACT_STR) begin
      if (m == MODE_STR_BARE) begin
        if (char_i == 8'h00) begin
          m = MODE_PLAIN;
        end else begin
          b[n] = char_i;
          n    = n + 3'd1;
        end
      end else if (m == MODE_STR_INCL) begin
        b[n] = char_i;
        n    = n + 3'd1;
        if (char_i == 8'h00) begin
          m = MODE_PLAIN;
        end
      end
    end

    // Format characters and the end of the format string.
    if (do_fmt) begin
      if (m == MODE_STR_BARE || m == MODE_STR_INCL) begin
        m = MODE_PLAIN;
      end
      if (m == MODE_PLAIN) begin
        if (fc == 8'h00) begin
          m = MODE_DONE;
        end else if (fc == "%") begin
          m = MODE_SPEC_FIRST;
        end else begin
          b[n] = fc;
          n    = n + 3'd1;
        end
      end else if (m == MODE_SPEC_FIRST) begin
        if (fc == "c") begin
          b[n] = arg_i[7:0];
          n    = n + 3'd1;
          m    = MODE_PLAIN;
        end else if (fc == "s") begin
          m = MODE_STR_BARE;
        end else begin
          b[n] = cfre_pkg::HEADER_BYTE;
          n    = n + 3'd1;
          conv = 1'b1;
        end
      end else if (m == MODE_SPEC) begin
        conv = 1'b1;
      end
    end

    // Conversion character of a specification.
    if (conv) begin
      unique case (fc)
        8'h00: begin
          b[n] = 8'h00;
          n    = n + 3'd1;
          m    = MODE_DONE;
        end
        "c", "*": begin
          b[n] = fc;
          n    = n + 3'd1;
          b[n] = arg_i[7:0];
          n    = n + 3'd1;
          m    = (fc == "c") ? MODE_PLAIN : MODE_SPEC;
        end
        "s": begin
          b[n] = fc;
          n    = n + 3'd1;
          m    = MODE_STR_INCL;
        end
        "e", "E", "f", "F", "g", "G": begin
          b[n] = fc;
          n    = n + 3'd1;
          b[n] = arg_i[7:0];
          n    = n + 3'd1;
          b[n] = arg_i[15:8];
          n    = n + 3'd1;
          b[n] = arg_i[23:16];
          n    = n + 3'd1;
          b[n] = arg_i[31:24];
          n    = n + 3'd1;
          m    = MODE_PLAIN;
        end
        "d", "i", "o", "x", "X", "u": begin
          if (p1 == "h") begin
            len = (p2 == "h") ? 3'd1 : 3'd2;
          end
          if (arg_i[31:8] == 24'd0) begin
            b[n] = fc + cfre_pkg::FLAG_BIT;
            len  = 3'd1;
          end else begin
            b[n] = fc;
          end
          n    = n + 3'd1;
          b[n] = arg_i[7:0];
          n    = n + 3'd1;
          if (len != 3'd1) begin
            b[n] = arg_i[15:8];
            n    = n + 3'd1;
          end
          if (len == 3'd4) begin
            b[n] = arg_i[23:16];
            n    = n + 3'd1;
            b[n] = arg_i[31:24];
            n    = n + 3'd1;
          end
          m = MODE_PLAIN;
        end
        "%": begin
          b[n] = fc;
          n    = n + 3'd1;
          m    = MODE_PLAIN;
        end
        default: begin
          b[n] = fc;
          n    = n + 3'd1;
          m    = MODE_SPEC;
        end
      endcase
    end

    mode_d        = m;
    entry_o.bytes = b;
    entry_o.n     = n;
    entry_o.done  = (m == MODE_DONE);
    entry_o.clr   = clr;
  end

  // Mode and character history advance on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      prev_q  <= 8'h00;
      prev2_q <= 8'h00;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
    end
  end

  // The mode never leaves its defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mode_q <= MODE_DONE)
    else $error("cfre_encode: undefined mode");

  // A new record is only ever opened from the done mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && entry_o.clr) |-> !(mode_q != MODE_DONE))
    else $error("cfre_encode: new record opened outside the done mode");

  // A transaction never produces more than the byte list holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> entry_o.n <= 3'(cfre_pkg::MAX_BYTES))
    else $error("cfre_encode: byte list overflow");

endmodule

`default_nettype wire
